/* design/sbr_pkg.sv */
// Shared types and constants of the spectrum band RMS block.
`default_nettype none

package sbr_pkg;

   // Configuration register file.
   localparam int EDGE_W    = 11;
   localparam int REG_IDX_W = 1;

   localparam logic [REG_IDX_W-1:0] REG_LOW_EDGE  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_EDGE = 1'b1;

   localparam logic [EDGE_W-1:0] LOW_EDGE_RESET  = 11'd8;
   localparam logic [EDGE_W-1:0] HIGH_EDGE_RESET = 11'd64;

   // Band codes, also the slot of each result in the response.
   localparam logic [1:0] BAND_TOTAL = 2'd0;
   localparam logic [1:0] BAND_LOW   = 2'd1;
   localparam logic [1:0] BAND_MID   = 2'd2;
   localparam logic [1:0] BAND_HIGH  = 2'd3;

   typedef struct packed {
      logic       take;        // input channel open
      logic       acc_clear;   // clear the frame sums and bin counter
      logic       div_start;
      logic       div_step;
      logic       sqrt_start;
      logic       sqrt_step;
      logic       store;       // latch the finished band result
      logic       load_out;    // move all four results to the output register
      logic [1:0] band;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic sqrt_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* design/spectrum_band_rms.sv */
// Top level of the spectrum band RMS block.
//
// Bins of one spectrum frame enter on the req_ channel, one request per
// cycle, with req_tlast on the final bin. Each bin is squared and added to
// the total sum and to one of the low, mid or high band sums, chosen by the
// bin index against csr low_edge (index 0) and high_edge (index 1).
// After the final bin req_tready drops while one shared restoring divider
// and one shared square root unit work through the four bands in turn.
// The sums are S = SUM_W bits wide (2*SAMPLE_BITS-1+log2 MAX_BINS, at most 64)
// and the roots ceil(S/2). The result becomes valid on rsp_ once the four
// bands are through; req_tready then rises again for the next frame.
// The result sits in an output register on the rsp_ channel; the next frame
// streams in while it waits, and only the load of the next result waits
// for rsp_tready. Reset restores the default edges, clears the sums and the
// bin counter and drops rsp_tvalid.
`default_nettype none

module spectrum_band_rms #(
   parameter int MAX_BINS    = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // bin_value
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   // last_bin
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // rms_total, rms_low, rms_mid, rms_high
   output logic      [((4*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [sbr_pkg::REG_IDX_W-1:0]      csr_index,
   input  wire logic [sbr_pkg::EDGE_W-1:0]         csr_wdata
);
   import sbr_pkg::*;

   cmd_type    cmd;
   status_type status;

   sbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tlast (req_tlast),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sbr_datapath #(
      .MAX_BINS   (MAX_BINS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

/* design/sbr_divider.sv */
// Restoring divider that produces one quotient bit per step.
`default_nettype none

module sbr_divider #(
   parameter int N_W = 41,
   parameter int D_W = 11
) (
   input  wire logic           clock,
   input  wire logic           start,
   input  wire logic           step,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic      [N_W-1:0] quotient
);

   logic [N_W-1:0] quot_ff, quot_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [D_W:0]   rem_shift;
   logic           fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[N_W-1]};
      fits      = rem_shift >= {1'b0, divisor};
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
      end else if (step) begin
         quot_in = {quot_ff[N_W-2:0], fits};
         rem_in  = fits ? D_W'(rem_shift - {1'b0, divisor}) : rem_shift[D_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quotient = quot_ff;

endmodule

`default_nettype wire

/* design/sbr_isqrt.sv */
// Digit-by-digit integer square root, one root bit per step.
`default_nettype none

module sbr_isqrt #(
   parameter int X_W = 42
) (
   input  wire logic             clock,
   input  wire logic             start,
   input  wire logic             step,
   input  wire logic [X_W-1:0]   radicand,
   output logic      [X_W/2-1:0] root
);

   localparam int RT_W = X_W / 2;

   logic [X_W-1:0]  rad_ff, rad_in;
   logic [RT_W-1:0] root_ff, root_in;
   logic [RT_W:0]   rem_ff, rem_in;
   logic [RT_W+2:0] rem_shift, trial;
   logic            fits;

   always_comb begin
      rem_shift = {rem_ff, rad_ff[X_W-1:X_W-2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = rem_shift >= trial;
      rad_in    = rad_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (step) begin
         rad_in  = {rad_ff[X_W-3:0], 2'b00};
         root_in = {root_ff[RT_W-2:0], fits};
         rem_in  = fits ? (RT_W+1)'(rem_shift - trial) : rem_shift[RT_W:0];
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign root = root_ff;

endmodule

`default_nettype wire

/* design/sbr_ctrl.sv */
// Frame sequencer: accumulation, then divide and square root for each band.
`default_nettype none

module sbr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tlast,
   output logic                    req_tready,
   input  wire sbr_pkg::status_type status,
   output sbr_pkg::cmd_type         cmd
);
   import sbr_pkg::*;

   typedef enum logic [7:0] {
      ST_ACCUM = 8'b0000_0001,
      ST_FLUSH = 8'b0000_0010,
      ST_START = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_SQS   = 8'b0001_0000,
      ST_SQRT  = 8'b0010_0000,
      ST_STORE = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] band_ff, band_in;

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      cmd      = '0;
      cmd.band = band_ff;
      case (state_ff)
         ST_ACCUM: begin
            cmd.take = 1'b1;
            if (req_tvalid && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         // The last square is still in the pipeline register here.
         ST_FLUSH: begin
            band_in  = BAND_TOTAL;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SQS;
            end
         end
         ST_SQS: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (band_ff == BAND_HIGH) begin
               state_in = ST_DONE;
            end else begin
               band_in  = band_ff + 2'd1;
               state_in = ST_START;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         band_ff  <= BAND_TOTAL;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
      end
   end

   assign req_tready = cmd.take;

endmodule

`default_nettype wire

/* design/sbr_datapath.sv */
// Band accumulators, band counts, shared divide and root units, result registers.
`default_nettype none

module sbr_datapath #(
   parameter int MAX_BINS    = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [sbr_pkg::REG_IDX_W-1:0]         csr_index,
   input  wire logic [sbr_pkg::EDGE_W-1:0]            csr_wdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [((4*SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,
   input  wire sbr_pkg::cmd_type                      cmd,
   output sbr_pkg::status_type                        status
);
   import sbr_pkg::*;

   localparam int OUT_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int CNT_W   = $clog2(MAX_BINS + 1);
   localparam int SQR_W   = 2 * SAMPLE_BITS;
   localparam int SUM_NAT = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BINS);
   localparam int SUM_W   = (SUM_NAT > 64) ? 64 : SUM_NAT;
   localparam int SQ_W    = SUM_W + (SUM_W % 2);
   localparam int RT_W    = SQ_W / 2;
   localparam int CMP_W   = (CNT_W > EDGE_W) ? CNT_W : EDGE_W;
   localparam int RC_W    = (RT_W > SAMPLE_BITS) ? RT_W : SAMPLE_BITS;
   localparam int IT_W    = $clog2(SUM_W + 1);

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SQR_W-1:0] b);
      logic [SUM_W:0] s;
      s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   // Configuration.
   logic [EDGE_W-1:0] low_ff, high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_EDGE_RESET;
         high_ff <= HIGH_EDGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_LOW_EDGE:  low_ff  <= csr_wdata;
            REG_HIGH_EDGE: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Square and band choice, registered ahead of the accumulators.
   logic                   accept, room;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CMP_W-1:0]       idx, lo, hi;
   logic [SAMPLE_BITS-1:0] sample, mag;
   logic [SQR_W-1:0]       sq_ff, sq_in;
   logic [1:0]             sel_ff, sel_in;
   logic                   pipe_v_ff, pipe_v_in;

   assign accept = cmd.take & req_tvalid;
   assign room   = count_ff < CNT_W'(MAX_BINS);
   assign idx    = CMP_W'(count_ff);
   assign lo     = CMP_W'(low_ff);
   assign hi     = CMP_W'(high_ff);
   assign sample = req_tdata[SAMPLE_BITS-1:0];
   assign mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

   always_comb begin
      sq_in     = SQR_W'(mag) * SQR_W'(mag);
      pipe_v_in = accept & room;
      if (idx < lo) begin
         sel_in = BAND_LOW;
      end else if (idx < hi) begin
         sel_in = BAND_MID;
      end else begin
         sel_in = BAND_HIGH;
      end
      count_in = count_ff;
      if (cmd.acc_clear) begin
         count_in = '0;
      end else if (accept && room) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Sums: slot BAND_TOTAL holds the whole frame, the others one band each.
   logic [SUM_W-1:0] sum_ff [4];
   logic [SUM_W-1:0] sum_in [4];

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         sum_in[b] = sum_ff[b];
         if (cmd.acc_clear) begin
            sum_in[b] = '0;
         end else if (pipe_v_ff && (b == 0 || sel_ff == 2'(b))) begin
            sum_in[b] = sat_add(sum_ff[b], sq_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pipe_v_ff <= 1'b0;
         for (int b = 0; b < 4; b++) begin
            sum_ff[b] <= '0;
         end
      end else begin
         count_ff  <= count_in;
         pipe_v_ff <= pipe_v_in;
         for (int b = 0; b < 4; b++) begin
            sum_ff[b] <= sum_in[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      sel_ff <= sel_in;
   end

   // Bin counts per band from the frame length and the edges.
   logic [CMP_W-1:0] n, hi_eff, n_low, n_mid_end, n_mid, n_high, cnt_wide;
   logic [CNT_W-1:0] cnt_sel;
   logic [SUM_W-1:0] sum_sel;

   always_comb begin
      n         = CMP_W'(count_ff);
      hi_eff    = (hi > lo) ? hi : lo;
      n_low     = (n < lo) ? n : lo;
      n_mid_end = (n < hi_eff) ? n : hi_eff;
      n_mid     = n_mid_end - n_low;
      n_high    = n - n_mid_end;
      case (cmd.band)
         BAND_TOTAL: cnt_wide = n;
         BAND_LOW:   cnt_wide = n_low;
         BAND_MID:   cnt_wide = n_mid;
         BAND_HIGH:  cnt_wide = n_high;
         default:    cnt_wide = n;
      endcase
      cnt_sel = cnt_wide[CNT_W-1:0];
      sum_sel = sum_ff[cmd.band];
   end

   // Shared divide and square root units.
   logic [SUM_W-1:0] quotient;
   logic [RT_W-1:0]  root;
   logic [IT_W-1:0]  iter_ff, iter_in;

   sbr_divider #(
      .N_W(SUM_W),
      .D_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .start   (cmd.div_start),
      .step    (cmd.div_step),
      .dividend(sum_sel),
      .divisor (cnt_sel),
      .quotient(quotient)
   );

   sbr_isqrt #(
      .X_W(SQ_W)
   ) u_sqrt (
      .clock   (clock),
      .start   (cmd.sqrt_start),
      .step    (cmd.sqrt_step),
      .radicand(SQ_W'(quotient)),
      .root    (root)
   );

   always_comb begin
      iter_in = iter_ff;
      if (cmd.div_start || cmd.sqrt_start) begin
         iter_in = '0;
      end else if (cmd.div_step || cmd.sqrt_step) begin
         iter_in = iter_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
   end

   // Band result: zero for an empty band or a zero sum, saturated to full scale.
   logic [RC_W-1:0]        root_ext, full_scale, root_sat;
   logic [SAMPLE_BITS-1:0] res_val;
   logic [SAMPLE_BITS-1:0] res_ff [4];
   logic [SAMPLE_BITS-1:0] rms_ff [4];
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      root_ext   = RC_W'(root);
      full_scale = RC_W'(1) << (SAMPLE_BITS - 1);
      root_sat   = (root_ext > full_scale) ? full_scale : root_ext;
      if (sum_sel == '0 || cnt_sel == '0) begin
         res_val = '0;
      end else begin
         res_val = root_sat[SAMPLE_BITS-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (cmd.store && cmd.band == 2'(b)) begin
            res_ff[b] <= res_val;
         end
         if (cmd.load_out) begin
            rms_ff[b] <= res_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = OUT_W'({rms_ff[3], rms_ff[2], rms_ff[1], rms_ff[0]});
   assign status.div_last  = iter_ff == IT_W'(SUM_W - 1);
   assign status.sqrt_last = iter_ff == IT_W'(RT_W - 1);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

/* tb/spectrum_band_rms_test.sv */
// Self-checking testbench for the spectrum band RMS block: frames, edges and band RMS results.
module spectrum_band_rms_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sbr_pkg::*;

   localparam int FRAME_MAX_BINS = 1024;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES   = 300;

   typedef struct {
      logic [15:0] value;
      logic        last;
   } bin_request_type;

   typedef struct {
      logic [15:0] total;
      logic [15:0] low;
      logic [15:0] mid;
      logic [15:0] high;
   } band_rms_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata   = '0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b1;
   logic [63:0]       rsp_tdata;
   logic              csr_we      = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = REG_LOW_EDGE;
   logic [EDGE_W-1:0] csr_wdata   = '0;

   // Pending bin requests and the band results they are expected to produce.
   bin_request_type bin_queue[$];
   band_rms_type    rms_expected[$];

   // Predictor copy of the block's configuration and frame state.
   logic [EDGE_W-1:0] low_edge_cfg  = LOW_EDGE_RESET;
   logic [EDGE_W-1:0] high_edge_cfg = HIGH_EDGE_RESET;
   int unsigned       frame_bins    = 0;
   longint unsigned   sum_low_band  = 0;
   longint unsigned   sum_mid_band  = 0;
   longint unsigned   sum_high_band = 0;

   int  error_count = 0;
   int  cycle_count = 0;
   int  req_gap     = 0;
   int  rsp_stall   = 0;
   logic steady_tail = 1'b0;

   spectrum_band_rms #(
      .MAX_BINS    (FRAME_MAX_BINS),
      .SAMPLE_BITS (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor RMS of one band in unsigned Q1.15, saturated at full scale.
   function automatic logic [15:0] band_root_mean(longint unsigned sum, int unsigned count);
      longint unsigned mean;
      longint unsigned root;
      longint unsigned trial;
      if (sum == 0 || count == 0) begin
         return 16'd0;
      end
      mean = sum / count;
      root = 0;
      for (int b = 21; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= mean) begin
            root = trial;
         end
      end
      if (root > 64'd32768) begin
         root = 64'd32768;
      end
      return root[15:0];
   endfunction

   task automatic accumulate_bin(logic [15:0] value, logic last);
      int              sample;
      int unsigned     mag;
      longint unsigned square;
      int unsigned     lo;
      int unsigned     hi_eff;
      int unsigned     n_low;
      int unsigned     n_mid_end;
      band_rms_type    rms;
      sample = $signed(value);
      mag    = (sample < 0) ? -sample : sample;
      square = longint'(mag) * mag;
      lo     = low_edge_cfg;
      hi_eff = (high_edge_cfg > low_edge_cfg) ? high_edge_cfg : low_edge_cfg;
      // Bins beyond the frame limit are dropped until the final bin.
      if (frame_bins < FRAME_MAX_BINS) begin
         if (frame_bins < lo) begin
            sum_low_band += square;
         end else if (frame_bins < high_edge_cfg) begin
            sum_mid_band += square;
         end else begin
            sum_high_band += square;
         end
         frame_bins++;
      end
      if (last) begin
         n_low     = (frame_bins < lo) ? frame_bins : lo;
         n_mid_end = (frame_bins < hi_eff) ? frame_bins : hi_eff;
         rms.total = band_root_mean(sum_low_band + sum_mid_band + sum_high_band, frame_bins);
         rms.low   = band_root_mean(sum_low_band, n_low);
         rms.mid   = band_root_mean(sum_mid_band, n_mid_end - n_low);
         rms.high  = band_root_mean(sum_high_band, frame_bins - n_mid_end);
         rms_expected.push_back(rms);
         frame_bins    = 0;
         sum_low_band  = 0;
         sum_mid_band  = 0;
         sum_high_band = 0;
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      bin_request_type next_bin;
      logic            send;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_bin(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            send = 1'b0;
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
            end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
               req_gap <= $urandom_range(0, 3);
            end else if (bin_queue.size() != 0) begin
               next_bin = bin_queue.pop_front();
               send     = 1'b1;
               req_tdata <= next_bin.value;
               req_tlast <= next_bin.last;
            end
            req_tvalid <= send;
         end
      end
   end

   // Result back-pressure: random stalls of rsp_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_stall  <= 0;
      end else if (rsp_stall != 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Result monitor.
   always @(posedge clock) begin
      band_rms_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rms_expected.size() == 0) begin
            $error("result with no request pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = rms_expected.pop_front();
            check_field("rms_total", want.total, rsp_tdata[15:0]);
            check_field("rms_low", want.low, rsp_tdata[31:16]);
            check_field("rms_mid", want.mid, rsp_tdata[47:32]);
            check_field("rms_high", want.high, rsp_tdata[63:48]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Returns at a falling edge once every request is sent and every result is in.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (bin_queue.size() != 0 || req_tvalid || rms_expected.size() != 0);
   endtask

   task automatic write_edges(logic [EDGE_W-1:0] lo, logic [EDGE_W-1:0] hi);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_LOW_EDGE;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= REG_HIGH_EDGE;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      low_edge_cfg  = lo;
      high_edge_cfg = hi;
      @(negedge clock);
   endtask

   task automatic push_bin(logic [15:0] value, logic last);
      bin_request_type item;
      item.value = value;
      item.last  = last;
      bin_queue.push_back(item);
   endtask

   function automatic logic [15:0] pick_bin_value();
      logic [15:0] small_mag;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1, 2: begin
            small_mag = 16'($urandom_range(0, 255));
            return $urandom_range(0, 1) ? -small_mag : small_mag;
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_frame(int nbins);
      logic silent;
      silent = ($urandom_range(0, 11) == 0);
      for (int k = 0; k < nbins; k++) begin
         push_bin(silent ? 16'h0000 : pick_bin_value(), k == nbins - 1);
      end
   endtask

   // Short random frames, at least n_bins requests in all, under one pair of edges.
   task automatic run_phase(int lo, int hi, int n_bins);
      int sent;
      int len;
      write_edges(EDGE_W'(lo), EDGE_W'(hi));
      sent = 0;
      while (sent < n_bins) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         push_frame(len);
         sent += len;
         // Now and then the sender holds off until all results are back.
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset edges: full-scale negative bin, full-scale positive bin, silent frame.
      push_bin(16'h8000, 1'b1);
      push_bin(16'h7FFF, 1'b0);
      push_bin(16'h0000, 1'b1);
      push_bin(16'h0000, 1'b0);
      push_bin(16'h0000, 1'b0);
      push_bin(16'h0000, 1'b1);
      // Two bins per band, extremes in each.
      write_edges(11'd2, 11'd4);
      push_bin(16'h7FFF, 1'b0);
      push_bin(16'h8000, 1'b0);
      push_bin(16'h0001, 1'b0);
      push_bin(16'hFFFF, 1'b0);
      push_bin(16'h0000, 1'b0);
      push_bin(16'd12345, 1'b1);

      run_phase(0, 0, 40);
      run_phase(1024, 1024, 40);
      run_phase(2047, 5, 30);
      run_phase(12, 5, 40);
      run_phase(0, 1024, 30);
      run_phase(0, 2047, 20);

      // One frame longer than the block keeps, then short frames behind it.
      write_edges(11'd300, 11'd700);
      push_frame(FRAME_MAX_BINS + 3);
      run_phase(300, 700, 20);

      repeat (4) begin
         run_phase($urandom_range(0, 16), $urandom_range(0, 40), 25);
      end
      steady_tail = 1'b1;
      run_phase($urandom_range(0, 16), $urandom_range(0, 40), 50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rms_expected.size() != 0) begin
         $error("%0d results never arrived", rms_expected.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
